// File: rtl/fbpm_pkg.sv
package fbpm_pkg;

	typedef logic [1:0] op_t;
	typedef logic [2:0] idx_t;
	typedef logic [3:0] cnt_t;

	localparam op_t OP_GET   = 2'd0;
	localparam op_t OP_PUT   = 2'd1;
	localparam op_t OP_STORE = 2'd2;
	localparam op_t OP_LOAD  = 2'd3;

	localparam cnt_t FRAMES_RESET = 4'd8;

endpackage

// File: rtl/fbpm_ram.sv
module fbpm_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 3
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/frame_buffer_pool_manager_core.sv
// Frame buffer pool manager. Free buffer indices live on a LIFO stack and
// filled frames on a FIFO ready queue, each held in a single-port-read RAM
// with a registered read port. Operations: get (pop free stack, or reclaim
// the oldest ready frame with dropped_oldest set), put, store, and load.
// Every input word yields exactly one result word. The RAM reads are issued
// when a word is accepted; the update stage then does the update, RAM
// write-back and output register load once the output register is free;
// in_ready stays low while a word is in that update stage, so one word is in
// flight at a time. The output register lets the next word enter while a
// result waits for out_ready. Writing cfg_wdata sets the free stack depth
// (clamped to 1..NUM_BUFFERS), refills the free stack with indices 0 upward
// and empties the ready queue; it takes effect at once and needs no clearing
// pass. Write it only while the block is idle.
module frame_buffer_pool_manager_core #(
	parameter int NUM_BUFFERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  fbpm_pkg::cnt_t       cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fbpm_pkg::op_t        operation,
	input  fbpm_pkg::idx_t       buffer_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 buffer_valid,
	output fbpm_pkg::idx_t       result_index,
	output logic                 dropped_oldest,
	output logic                 overflow_error,
	output fbpm_pkg::cnt_t       free_count,
	output fbpm_pkg::cnt_t       ready_count
);
	import fbpm_pkg::*;

	localparam int AW = $clog2(NUM_BUFFERS);
	localparam int DW = $clog2(NUM_BUFFERS + 1);
	localparam int CW = (DW > 4) ? DW : 4;
	localparam logic [DW-1:0] FULL = DW'(NUM_BUFFERS);
	localparam int RST_N = (NUM_BUFFERS < 8) ? NUM_BUFFERS : 8;
	localparam logic [DW-1:0] RST_DEPTH = DW'(RST_N);

	// pool state
	logic [DW-1:0] free_depth_q, low_mark_q, ready_depth_q;
	logic [AW-1:0] head_q, tail_q;

	// update stage
	logic          busy_s1;
	op_t           op_s1;
	idx_t          idx_s1;
	logic          fwd_s1;
	idx_t          pos_s1;

	// output register
	logic          out_valid_q, buffer_valid_q, dropped_q, ovf_q;
	idx_t          result_q;
	cnt_t          free_count_q, ready_count_q;

	logic          in_acc, done;
	logic [DW-1:0] pos;
	logic [DW+2:0] pos_x;
	logic [CW-1:0] cfg_x, cfg_n;
	idx_t          free_rdata, ring_rdata;

	logic          free_we, ring_we;
	logic [DW-1:0] free_depth_d, low_mark_d, ready_depth_d;
	logic [AW-1:0] head_d, tail_d;
	logic          valid_d, dropped_d, ovf_d;
	idx_t          result_d;
	logic [CW-1:0] free_cnt_x, ready_cnt_x;

	assign in_ready = !busy_s1;
	assign in_acc   = in_valid && !busy_s1;
	assign done     = busy_s1 && (!out_valid_q || out_ready);

	assign pos   = free_depth_q - DW'(1);
	assign pos_x = {3'b000, pos};

	assign cfg_x = CW'(cfg_wdata);
	assign cfg_n = (cfg_x == '0) ? CW'(1) :
		((cfg_x > CW'(NUM_BUFFERS)) ? CW'(NUM_BUFFERS) : cfg_x);

	fbpm_ram #(.DEPTH(NUM_BUFFERS), .WIDTH(3)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_depth_q[AW-1:0]),
		.wdata (idx_s1),
		.re    (in_acc),
		.raddr (pos[AW-1:0]),
		.rdata (free_rdata)
	);

	fbpm_ram #(.DEPTH(NUM_BUFFERS), .WIDTH(3)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (tail_q),
		.wdata (idx_s1),
		.re    (in_acc),
		.raddr (head_q),
		.rdata (ring_rdata)
	);

	always_comb begin
		free_we       = 1'b0;
		ring_we       = 1'b0;
		free_depth_d  = free_depth_q;
		low_mark_d    = low_mark_q;
		ready_depth_d = ready_depth_q;
		head_d        = head_q;
		tail_d        = tail_q;
		valid_d       = 1'b0;
		dropped_d     = 1'b0;
		ovf_d         = 1'b0;
		result_d      = '0;
		unique case (op_s1)
			OP_GET: begin
				if (free_depth_q != '0) begin
					free_depth_d = pos;
					valid_d      = 1'b1;
					result_d     = fwd_s1 ? pos_s1 : free_rdata;
					if (pos < low_mark_q) begin
						low_mark_d = pos;
					end
				end else if (ready_depth_q != '0) begin
					valid_d       = 1'b1;
					dropped_d     = 1'b1;
					result_d      = ring_rdata;
					ready_depth_d = ready_depth_q - DW'(1);
					head_d        = (head_q == AW'(NUM_BUFFERS - 1)) ? '0 : head_q + AW'(1);
				end
			end
			OP_PUT: begin
				if (free_depth_q == FULL) begin
					ovf_d = 1'b1;
				end else begin
					free_we      = busy_s1 && done;
					free_depth_d = free_depth_q + DW'(1);
				end
			end
			OP_STORE: begin
				if (ready_depth_q == FULL) begin
					ovf_d = 1'b1;
				end else begin
					ring_we       = busy_s1 && done;
					ready_depth_d = ready_depth_q + DW'(1);
					tail_d        = (tail_q == AW'(NUM_BUFFERS - 1)) ? '0 : tail_q + AW'(1);
				end
			end
			OP_LOAD: begin
				if (ready_depth_q != '0) begin
					valid_d       = 1'b1;
					result_d      = ring_rdata;
					ready_depth_d = ready_depth_q - DW'(1);
					head_d        = (head_q == AW'(NUM_BUFFERS - 1)) ? '0 : head_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
		free_cnt_x  = CW'(free_depth_d);
		ready_cnt_x = CW'(ready_depth_d);
	end

	// low_mark_q: stack slots below it are unwritten since reset or config and read as their slot number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q  <= RST_DEPTH;
			low_mark_q    <= RST_DEPTH;
			ready_depth_q <= '0;
			head_q        <= '0;
			tail_q        <= '0;
		end else if (cfg_we) begin
			free_depth_q  <= DW'(cfg_n);
			low_mark_q    <= DW'(cfg_n);
			ready_depth_q <= '0;
			head_q        <= '0;
			tail_q        <= '0;
		end else if (done) begin
			free_depth_q  <= free_depth_d;
			low_mark_q    <= low_mark_d;
			ready_depth_q <= ready_depth_d;
			head_q        <= head_d;
			tail_q        <= tail_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_acc) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= operation;
			idx_s1 <= buffer_index;
			fwd_s1 <= pos < low_mark_q;
			pos_s1 <= pos_x[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			buffer_valid_q <= valid_d;
			result_q       <= result_d;
			dropped_q      <= dropped_d;
			ovf_q          <= ovf_d;
			free_count_q   <= free_cnt_x[3:0];
			ready_count_q  <= ready_cnt_x[3:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign buffer_valid   = buffer_valid_q;
	assign result_index   = result_q;
	assign dropped_oldest = dropped_q;
	assign overflow_error = ovf_q;
	assign free_count     = free_count_q;
	assign ready_count    = ready_count_q;

endmodule

// File: tb/tb_frame_buffer_pool_manager_core.sv
`timescale 1ns / 1ps
module tb_frame_buffer_pool_manager_core;
	import fbpm_pkg::*;

	localparam int NBUF = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 10;
	localparam int PHASE_WORDS = 155;

	typedef struct packed {
		logic buffer_valid;
		idx_t result_index;
		logic dropped_oldest;
		logic overflow_error;
		cnt_t free_count;
		cnt_t ready_count;
	} pool_result_t;

	class pool_scoreboard;
		idx_t free_stk [NBUF];
		idx_t ready_ring [NBUF];
		cnt_t free_dep;
		cnt_t ready_dep;
		idx_t head;
		idx_t tail;
		pool_result_t expected_q [$];
		int mismatches;

		function new();
			mismatches = 0;
			set_pool(FRAMES_RESET);
		endfunction

		function void set_pool(cnt_t frames);
			cnt_t n;
			n = (frames < 1) ? cnt_t'(1) : (frames > NBUF) ? cnt_t'(NBUF) : frames;
			for (int i = 0; i < NBUF; i++) begin
				free_stk[i] = (i < n) ? idx_t'(i) : '0;
				ready_ring[i] = '0;
			end
			free_dep = n;
			ready_dep = '0;
			head = '0;
			tail = '0;
		endfunction

		function void note_word(op_t op, idx_t idx);
			pool_result_t r;
			r = '0;
			case (op)
			OP_GET: begin
				if (free_dep != 0) begin
					free_dep = free_dep - 1;
					r.result_index = free_stk[free_dep];
					r.buffer_valid = 1'b1;
				end else if (ready_dep != 0) begin
					r.result_index = ready_ring[head];
					head = head + 1;
					ready_dep = ready_dep - 1;
					r.buffer_valid = 1'b1;
					r.dropped_oldest = 1'b1;
				end
			end
			OP_PUT: begin
				if (free_dep >= NBUF) begin
					r.overflow_error = 1'b1;
				end else begin
					free_stk[free_dep] = idx;
					free_dep = free_dep + 1;
				end
			end
			OP_STORE: begin
				if (ready_dep >= NBUF) begin
					r.overflow_error = 1'b1;
				end else begin
					ready_ring[tail] = idx;
					tail = tail + 1;
					ready_dep = ready_dep + 1;
				end
			end
			default: begin
				if (ready_dep != 0) begin
					r.result_index = ready_ring[head];
					head = head + 1;
					ready_dep = ready_dep - 1;
					r.buffer_valid = 1'b1;
				end
			end
			endcase
			r.free_count = free_dep;
			r.ready_count = ready_dep;
			expected_q.push_back(r);
		endfunction

		function void report(string what, pool_result_t exp, pool_result_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: exp valid=%0b idx=%0d drop=%0b ovf=%0b free=%0d ready=%0d | got valid=%0b idx=%0d drop=%0b ovf=%0b free=%0d ready=%0d",
					what, exp.buffer_valid, exp.result_index, exp.dropped_oldest,
					exp.overflow_error, exp.free_count, exp.ready_count,
					got.buffer_valid, got.result_index, got.dropped_oldest,
					got.overflow_error, got.free_count, got.ready_count);
		endfunction

		function void check_word(pool_result_t got);
			pool_result_t exp;
			if (expected_q.size() == 0) begin
				report("unexpected word", '0, got);
				return;
			end
			exp = expected_q.pop_front();
			if (got.buffer_valid !== exp.buffer_valid ||
				got.result_index !== exp.result_index ||
				got.dropped_oldest !== exp.dropped_oldest ||
				got.overflow_error !== exp.overflow_error ||
				got.free_count !== exp.free_count ||
				got.ready_count !== exp.ready_count)
				report("mismatch", exp, got);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cnt_t cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	op_t operation = OP_GET;
	idx_t buffer_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic buffer_valid;
	idx_t result_index;
	logic dropped_oldest;
	logic overflow_error;
	cnt_t free_count;
	cnt_t ready_count;

	pool_scoreboard pool;
	int quiet_cycles = 0;
	int stall_left = 0;
	int stall_pct = 0;

	frame_buffer_pool_manager_core #(
		.NUM_BUFFERS(NBUF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.buffer_index(buffer_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.buffer_valid(buffer_valid),
		.result_index(result_index),
		.dropped_oldest(dropped_oldest),
		.overflow_error(overflow_error),
		.free_count(free_count),
		.ready_count(ready_count)
	);

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				pool.check_word(pool_result_t'({buffer_valid, result_index, dropped_oldest,
					overflow_error, free_count, ready_count}));
			if (in_valid && in_ready)
				pool.note_word(operation, buffer_index);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(1, 19);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(op_t op, idx_t idx);
		in_valid <= 1'b1;
		operation <= op;
		buffer_index <= idx;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold off input until every outstanding word has returned
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pool.expected_q.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_pool_size(cnt_t frames);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= frames;
		@(posedge clk);
		pool.set_pool(frames);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		cnt_t pool_frames;
		op_t op;
		int gap_pct;
		int pause_at;
		int w_get;
		int w_put;
		int w_store;
		int w_load;
		int roll;

		pool = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full free stack after reset
		send_word(OP_LOAD, 3'd0);
		send_word(OP_PUT, 3'd5);
		send_word(OP_GET, 3'd0);
		send_word(OP_PUT, 3'd7);

		// single buffer: exhaust both stores, fill ready queue, reclaim oldest
		write_pool_size(4'd1);
		send_word(OP_GET, 3'd0);
		send_word(OP_GET, 3'd0);
		send_word(OP_LOAD, 3'd0);
		for (int i = 7; i >= 0; i--)
			send_word(OP_STORE, idx_t'(i));
		send_word(OP_STORE, 3'd3);
		send_word(OP_GET, 3'd0);
		send_word(OP_LOAD, 3'd0);

		// out-of-range sizes clamp
		write_pool_size(4'd0);
		send_word(OP_GET, 3'd0);
		send_word(OP_GET, 3'd0);
		write_pool_size(4'd15);
		send_word(OP_PUT, 3'd2);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: pool_frames = 4'd8;
			1: pool_frames = 4'd1;
			2: pool_frames = 4'd15;
			3: pool_frames = 4'd0;
			default: pool_frames = cnt_t'($urandom_range(0, 15));
			endcase
			write_pool_size(pool_frames);
			if (p == PHASES - 1) begin
				stall_pct = 0;
				gap_pct = 0;
			end else begin
				stall_pct = 10 * $urandom_range(0, 3);
				gap_pct = 10 * $urandom_range(0, 3);
			end
			w_get = $urandom_range(1, 8);
			w_put = $urandom_range(1, 8);
			w_store = $urandom_range(1, 8);
			w_load = $urandom_range(1, 8);
			pause_at = $urandom_range(0, PHASE_WORDS - 1);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k == pause_at)
					drain();
				if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 19)) @(posedge clk);
				end
				roll = $urandom_range(1, w_get + w_put + w_store + w_load);
				if (roll <= w_get)
					op = OP_GET;
				else if (roll <= w_get + w_put)
					op = OP_PUT;
				else if (roll <= w_get + w_put + w_store)
					op = OP_STORE;
				else
					op = OP_LOAD;
				send_word(op, idx_t'($urandom_range(0, 7)));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (pool.mismatches == 0 && pool.expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
